[rtl/upd_pkg.sv]
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        PH_NONE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_DIGIT   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last;
    } upd_entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            v = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

[rtl/upd_front.sv]
module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       q_full,
    output logic       q_push,
    output upd_entry_t q_entry
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [7:0] buf_b [4];
    logic [1:0] n;
    logic       do_plain;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        buf_b      = '{default: 8'h00};
        n          = 2'd0;
        phase_next = phase_reg;
        held_next  = held_reg;
        do_plain   = 1'b0;
        case (phase_reg)
            PH_PERCENT:
            begin
                if (is_hex(in_char))
                begin
                    held_next  = in_char;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    buf_b[n]   = CH_PERCENT;
                    n          = n + 2'd1;
                    phase_next = PH_NONE;
                    do_plain   = 1'b1;
                end
            end
            PH_DIGIT:
            begin
                if (is_hex(in_char))
                begin
                    buf_b[n]   = {hex_val(held_reg), hex_val(in_char)};
                    n          = n + 2'd1;
                    phase_next = PH_NONE;
                    held_next  = 8'h00;
                end
                else
                begin
                    buf_b[n]   = CH_PERCENT;
                    n          = n + 2'd1;
                    buf_b[n]   = held_reg;
                    n          = n + 2'd1;
                    phase_next = PH_NONE;
                    held_next  = 8'h00;
                    do_plain   = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_NONE;
                do_plain   = 1'b1;
            end
        endcase

        if (do_plain)
        begin
            if (in_char == CH_PERCENT)
            begin
                phase_next = PH_PERCENT;
            end
            else
            begin
                buf_b[n] = (in_char == CH_PLUS) ? CH_SPACE : in_char;
                n        = n + 2'd1;
            end
        end

        // flush whatever is pending at the string end
        if (in_last)
        begin
            if (phase_next == PH_PERCENT)
            begin
                buf_b[n] = CH_PERCENT;
                n        = n + 2'd1;
            end
            else if (phase_next == PH_DIGIT)
            begin
                buf_b[n] = CH_PERCENT;
                n        = n + 2'd1;
                buf_b[n] = held_next;
                n        = n + 2'd1;
            end
            phase_next = PH_NONE;
            held_next  = 8'h00;
        end

        q_entry.bytes[0] = buf_b[0];
        q_entry.bytes[1] = buf_b[1];
        q_entry.bytes[2] = buf_b[2];
        q_entry.count    = n;
        q_entry.last     = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NONE;
            held_reg  <= 8'h00;
        end
        else if (q_push)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

[rtl/upd_fifo.sv]
module upd_fifo
    import upd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  upd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       head_valid,
    output upd_entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    upd_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (full |-> (!push || pop)) and (!head_valid |-> !pop))
        else $error("queue pushed while full or popped while empty");

endmodule

[rtl/upd_back.sv]
module upd_back
    import upd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        head_valid,
    input  upd_entry_t  head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        overflow,
    output logic        run_end,
    output logic        string_end
);

    logic [15:0] max_reg;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        failed_reg;
    logic        failed_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        overflow_reg;
    logic        run_end_reg;
    logic        string_end_reg;
    logic        adv;
    logic        load;
    logic [7:0]  ld_byte;
    logic        ld_ovf;
    logic        ld_run_end;
    logic        ld_string_end;
    logic [7:0]  cur_byte;
    logic        is_final;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = head.bytes[0];
            2'd1:    cur_byte = head.bytes[1];
            default: cur_byte = head.bytes[2];
        endcase
    end

    assign is_final = (idx_reg == head.count - 2'd1);

    always_comb
    begin
        pop           = 1'b0;
        load          = 1'b0;
        ld_byte       = 8'h00;
        ld_ovf        = 1'b0;
        ld_run_end    = 1'b0;
        ld_string_end = 1'b0;
        count_next    = count_reg;
        failed_next   = failed_reg;
        idx_next      = idx_reg;
        if (head_valid)
        begin
            if (failed_reg || head.count == 2'd0)
            begin
                // drop: nothing to emit
                pop      = 1'b1;
                idx_next = 2'd0;
                if (head.last)
                begin
                    count_next  = 16'd0;
                    failed_next = 1'b0;
                end
            end
            else if (adv)
            begin
                load = 1'b1;
                if (count_reg >= max_reg)
                begin
                    ld_ovf        = 1'b1;
                    ld_run_end    = 1'b1;
                    ld_string_end = head.last;
                    pop           = 1'b1;
                    idx_next      = 2'd0;
                    failed_next   = !head.last;
                    if (head.last)
                    begin
                        count_next = 16'd0;
                    end
                end
                else
                begin
                    ld_byte       = cur_byte;
                    ld_run_end    = is_final;
                    ld_string_end = is_final && head.last;
                    count_next    = count_reg + 16'd1;
                    if (is_final)
                    begin
                        pop      = 1'b1;
                        idx_next = 2'd0;
                        if (head.last)
                        begin
                            count_next = 16'd0;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= 16'hFFFF;
            count_reg     <= 16'd0;
            failed_reg    <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            count_reg  <= count_next;
            failed_reg <= failed_next;
            idx_reg    <= idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= ld_byte;
            overflow_reg   <= ld_ovf;
            run_end_reg    <= ld_run_end;
            string_end_reg <= ld_string_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign overflow   = overflow_reg;
    assign run_end    = run_end_reg;
    assign string_end = string_end_reg;

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && overflow_reg |-> out_byte_reg == 8'h00 && run_end_reg)
        else $error("overflow beat carries data or lacks run end");

    a_end_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && string_end_reg |-> run_end_reg)
        else $error("string end without run end");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && !failed_reg && head.count != 2'd0 |-> idx_reg < head.count)
        else $error("byte index past entry count");

    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !load)
        else $error("beat emitted after overflow");

endmodule

[rtl/url_percent_decoder.sv]
// channel  signals                                       direction
// input    in_valid, in_ready, in_char, in_last          beat in
// output   out_valid, out_ready, out_byte, overflow,
//          run_end, string_end                           beat out
// config   cfg_we, cfg_data (max_output_chars)           write only
//
// The front accepts one character per cycle while the queue has room.
// The back emits one decoded byte per cycle from a registered output while the output is not stalled;
// an item that decodes to 2 or 3 bytes holds the back until its last byte is loaded.
// Items with nothing to emit, and items after an overflow, are popped without waiting for the output.
// Reset clears escape state, counters and the queue; the limit resets to 65535.
// A stalled output holds the back; the queue then fills and drops in_ready.
module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        overflow,
    output logic        run_end,
    output logic        string_end
);

    logic       q_full;
    logic       q_push;
    upd_entry_t q_entry;
    logic       q_pop;
    logic       q_head_valid;
    upd_entry_t q_head;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_char  (in_char),
        .in_last  (in_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    upd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .overflow   (overflow),
        .run_end    (run_end),
        .string_end (string_end)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
    import upd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       ovf;
        logic       run_end;
        logic       str_end;
    } decoded_t;

    typedef enum logic [0:0] {
        ROW_BEAT  = 1'b0,
        ROW_LIMIT = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [15:0] value;
        logic       last;
        logic       typed;
        logic       has_result;
        decoded_t   result;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_char = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        overflow;
    logic        run_end;
    logic        string_end;

    // decoder state mirror
    logic [15:0] char_limit;
    phase_t      esc_phase;
    logic [7:0]  first_digit;
    logic [15:0] bytes_out;
    logic        string_failed;
    logic [7:0]  decoded_bytes[$];
    decoded_t    expected_beats[$];

    // handoff from the sender for rows with a typed result
    logic        beat_typed = 1'b0;
    logic        beat_has_result = 1'b0;
    decoded_t    beat_result = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int hold_left = 0;

    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int overflows_seen = 0;
    int beats_sent = 0;
    int strings_sent = 0;
    int input_stalls = 0;

    row_t directed[$];

    url_percent_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .overflow   (overflow),
        .run_end    (run_end),
        .string_end (string_end)
    );

    always #4 clk = ~clk;

    function automatic logic hex_digit_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61)
        begin
            v = c - 8'h57;
        end
        else
        begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    task automatic clear_string_state();
        esc_phase = PH_NONE;
        first_digit = 8'h00;
        bytes_out = 16'd0;
        string_failed = 1'b0;
    endtask

    task automatic take_plain(input logic [7:0] c);
        if (c == CH_PERCENT)
        begin
            esc_phase = PH_PERCENT;
        end
        else if (c == CH_PLUS)
        begin
            decoded_bytes.push_back(CH_SPACE);
        end
        else
        begin
            decoded_bytes.push_back(c);
        end
    endtask

    task automatic decode_beat(input logic [7:0] c, input logic last);
        decoded_t res[3];
        int n;
        logic stop;
        decoded_bytes.delete();
        n = 0;
        stop = 1'b0;
        if (string_failed)
        begin
            if (last)
            begin
                clear_string_state();
            end
        end
        else
        begin
            case (esc_phase)
                PH_PERCENT:
                begin
                    if (hex_digit_ok(c))
                    begin
                        first_digit = c;
                        esc_phase = PH_DIGIT;
                    end
                    else
                    begin
                        decoded_bytes.push_back(CH_PERCENT);
                        esc_phase = PH_NONE;
                        take_plain(c);
                    end
                end
                PH_DIGIT:
                begin
                    if (hex_digit_ok(c))
                    begin
                        decoded_bytes.push_back({nibble_of(first_digit), nibble_of(c)});
                        esc_phase = PH_NONE;
                        first_digit = 8'h00;
                    end
                    else
                    begin
                        decoded_bytes.push_back(CH_PERCENT);
                        decoded_bytes.push_back(first_digit);
                        esc_phase = PH_NONE;
                        first_digit = 8'h00;
                        take_plain(c);
                    end
                end
                default:
                begin
                    esc_phase = PH_NONE;
                    take_plain(c);
                end
            endcase
            if (last)
            begin
                if (esc_phase == PH_PERCENT)
                begin
                    decoded_bytes.push_back(CH_PERCENT);
                end
                else if (esc_phase == PH_DIGIT)
                begin
                    decoded_bytes.push_back(CH_PERCENT);
                    decoded_bytes.push_back(first_digit);
                end
                esc_phase = PH_NONE;
                first_digit = 8'h00;
            end
            for (int i = 0; i < decoded_bytes.size() && !stop; i++)
            begin
                if (bytes_out >= char_limit)
                begin
                    res[n] = '{data: 8'h00, ovf: 1'b1, run_end: 1'b0, str_end: 1'b0};
                    n++;
                    string_failed = 1'b1;
                    esc_phase = PH_NONE;
                    first_digit = 8'h00;
                    stop = 1'b1;
                end
                else
                begin
                    res[n] = '{data: decoded_bytes[i], ovf: 1'b0, run_end: 1'b0,
                               str_end: 1'b0};
                    n++;
                    bytes_out = bytes_out + 16'd1;
                end
            end
            if (n > 0)
            begin
                res[n-1].run_end = 1'b1;
                res[n-1].str_end = last;
            end
            for (int i = 0; i < n; i++)
            begin
                expected_beats.push_back(res[i]);
            end
            if (last)
            begin
                clear_string_state();
            end
        end
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // sample both channels and the config port at the rising edge
    always @(posedge clk)
    begin : monitor
        decoded_t got;
        decoded_t want;
        int prev_count;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{data: out_byte, ovf: overflow, run_end: run_end,
                        str_end: string_end};
                results_checked++;
                if (overflow)
                begin
                    overflows_seen++;
                end
                if (expected_beats.size() == 0)
                begin
                    note_failure($sformatf("unexpected beat: byte %02h ovf %b run %b str %b",
                                           got.data, got.ovf, got.run_end, got.str_end));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                    begin
                        note_failure($sformatf(
                            "mismatch: exp byte %02h ovf %b run %b str %b, got %02h %b %b %b",
                            want.data, want.ovf, want.run_end, want.str_end,
                            got.data, got.ovf, got.run_end, got.str_end));
                    end
                end
            end
            if (cfg_we)
            begin
                char_limit = cfg_data;
            end
            if (in_valid && !in_ready)
            begin
                input_stalls++;
            end
            if (in_valid && in_ready)
            begin
                prev_count = expected_beats.size();
                decode_beat(in_char, in_last);
                if (beat_typed)
                begin
                    while (expected_beats.size() > prev_count)
                    begin
                        void'(expected_beats.pop_back());
                    end
                    if (beat_has_result)
                    begin
                        expected_beats.push_back(beat_result);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold on request
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic last, input logic typed,
                             input logic has, input decoded_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        beat_typed = typed;
        beat_has_result = has;
        beat_result = res;
        in_valid <= 1'b1;
        in_char <= c;
        in_last <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic set_limit(input logic [15:0] v);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] random_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10)
        begin
            return 8'(8'h30 + r);
        end
        else if (r < 16)
        begin
            return 8'(8'h61 + r - 10);
        end
        return 8'(8'h41 + r - 16);
    endfunction

    task automatic send_random_string(input int target);
        logic [7:0] text[$];
        int r;
        while (text.size() < target)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                text.push_back(CH_PERCENT);
                text.push_back(random_hex());
                text.push_back(random_hex());
            end
            else if (r < 67)
            begin
                text.push_back(CH_PLUS);
            end
            else if (r < 82)
            begin
                text.push_back(8'(8'h67 + $urandom_range(19)));
            end
            else if (r < 90)
            begin
                text.push_back(CH_PERCENT);
                if ($urandom_range(1))
                begin
                    text.push_back(random_hex());
                end
                if ($urandom_range(1))
                begin
                    text.push_back(CH_PERCENT);
                end
                else
                begin
                    text.push_back(8'(8'h67 + $urandom_range(19)));
                end
            end
            else
            begin
                text.push_back(8'($urandom_range(1, 255)));
            end
        end
        for (int i = 0; i < text.size(); i++)
        begin
            send_beat(text[i], i == text.size() - 1, 1'b0, 1'b0, '0);
        end
        strings_sent++;
    endtask

    task automatic run_strings(input int beats, input int max_len);
        int start;
        int len;
        start = beats_sent;
        while (beats_sent - start < beats)
        begin
            if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(15, 30);
            end
            else
            begin
                len = $urandom_range(1, max_len);
            end
            send_random_string(len);
        end
    endtask

    function automatic row_t step_row(input logic [7:0] c, input logic last);
        return '{kind: ROW_BEAT, value: {8'h00, c}, last: last, typed: 1'b0,
                 has_result: 1'b0, result: '0};
    endfunction

    function automatic row_t known_row(input logic [7:0] c, input logic last,
                                       input logic has, input logic [7:0] data,
                                       input logic ovf, input logic str);
        return '{kind: ROW_BEAT, value: {8'h00, c}, last: last, typed: 1'b1,
                 has_result: has,
                 result: '{data: data, ovf: ovf, run_end: 1'b1, str_end: str}};
    endfunction

    function automatic row_t limit_row(input logic [15:0] v);
        return '{kind: ROW_LIMIT, value: v, last: 1'b0, typed: 1'b0,
                 has_result: 1'b0, result: '0};
    endfunction

    initial
    begin
        char_limit = 16'hFFFF;
        clear_string_state();

        directed.push_back(known_row("A", 1'b0, 1'b1, "A", 1'b0, 1'b0));
        directed.push_back(known_row("+", 1'b0, 1'b1, CH_SPACE, 1'b0, 1'b0));
        directed.push_back(known_row("%", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        directed.push_back(known_row("a", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        directed.push_back(known_row("F", 1'b0, 1'b1, 8'hAF, 1'b0, 1'b0));
        directed.push_back(step_row("%", 1'b0));
        directed.push_back(step_row("7", 1'b0));
        directed.push_back(step_row("z", 1'b0));
        directed.push_back(step_row("%", 1'b0));
        directed.push_back(step_row("%", 1'b0));
        directed.push_back(step_row("+", 1'b0));
        directed.push_back(known_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0));
        directed.push_back(known_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
        directed.push_back(known_row(8'h01, 1'b1, 1'b1, 8'h01, 1'b0, 1'b1));
        directed.push_back(known_row("%", 1'b1, 1'b1, CH_PERCENT, 1'b0, 1'b1));
        directed.push_back(step_row("%", 1'b0));
        directed.push_back(step_row("c", 1'b1));
        directed.push_back(limit_row(16'd0));
        directed.push_back(known_row("x", 1'b1, 1'b1, 8'h00, 1'b1, 1'b1));
        directed.push_back(known_row("x", 1'b0, 1'b1, 8'h00, 1'b1, 1'b0));
        directed.push_back(known_row("y", 1'b0, 1'b0, 8'h00, 1'b0, 1'b0));
        directed.push_back(known_row("z", 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
        directed.push_back(limit_row(16'd1));
        directed.push_back(step_row("%", 1'b0));
        directed.push_back(step_row("4", 1'b0));
        directed.push_back(step_row("z", 1'b0));
        directed.push_back(step_row("q", 1'b1));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 87;
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_LIMIT)
            begin
                set_limit(directed[i].value);
            end
            else
            begin
                send_beat(directed[i].value[7:0], directed[i].last, directed[i].typed,
                          directed[i].has_result, directed[i].result);
            end
        end

        set_limit(16'($urandom_range(2, 6)));
        run_strings(70, 10);

        send_idle_pct = 87;
        recv_idle_pct = 18;
        set_limit(16'hFFFF);
        run_strings(70, 10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limit(16'($urandom_range(7, 14)));
        run_strings(60, 12);

        // hold the output off while the sender keeps pushing
        set_limit(16'hFFFF);
        hold_toggle = ~hold_toggle;
        run_strings(70, 12);

        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d strings, %0d beats in, %0d results checked, %0d overflows",
                 strings_sent, beats_sent, results_checked, overflows_seen);
        $display("limits 0, 1, small and 65535; %0d input stall cycles under backpressure",
                 input_stalls);
        if (mismatches == 0 && expected_beats.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
